// ----- rtl/td2b_pkg.sv -----
// Shared types and constants for the text dictionary to binary record converter.
// No dependencies.
package td2b_pkg;

  localparam int unsigned NumRes = 5;
  localparam int unsigned CntW   = 3;

  localparam logic [1:0] MODE_LINE   = 2'd0;
  localparam logic [1:0] MODE_NUMBER = 2'd1;
  localparam logic [1:0] MODE_WORD   = 2'd2;
  localparam logic [1:0] MODE_ERROR  = 2'd3;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_EOI  = 1'b1;

  localparam logic TGT_BODY   = 1'b0;
  localparam logic TGT_HEADER = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Results caused by one item, held until transferred one per unstalled cycle.
  typedef struct packed {
    logic [CntW-1:0]          cnt;
    logic [NumRes-1:0][7:0]   bytes;
    logic [NumRes-1:0]        tgt;
    logic                     err;
  } bundle_t;

endpackage

// ----- rtl/td2b_parse.sv -----
// Line parser: mode, weight and word count registers, and the result bundle
// for the item being accepted. Depends on td2b_pkg.
module td2b_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic              kind,
  input  logic [7:0]        text_byte,
  output td2b_pkg::bundle_t res
);
  import td2b_pkg::*;

  logic [1:0]  mode_r,   mode_nxt;
  logic [15:0] accum_r,  accum_nxt;
  logic        over_r,   over_nxt;
  logic        neg_r,    neg_nxt;
  logic        digits_r, digits_nxt;
  logic [31:0] wc_r,     wc_nxt;

  logic        is_space, is_digit;
  logic [3:0]  digit;
  logic [19:0] prod;
  logic [15:0] weight;
  logic [31:0] wc_inc;

  assign is_space = (text_byte == CH_SPACE) || ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
  assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign digit    = text_byte[3:0];
  assign prod     = {1'b0, accum_r, 3'b000} + {3'b000, accum_r, 1'b0} + {16'd0, digit};
  assign weight   = neg_r ? (16'd0 - accum_r) : (over_r ? 16'hFFFF : accum_r);
  assign wc_inc   = wc_r + 32'd1;

  always_comb begin
    mode_nxt   = mode_r;
    accum_nxt  = accum_r;
    over_nxt   = over_r;
    neg_nxt    = neg_r;
    digits_nxt = digits_r;
    wc_nxt     = wc_r;
    res        = '0;

    if (kind == KIND_EOI) begin
      unique case (mode_r)
        MODE_NUMBER, MODE_ERROR: begin
          res.cnt = CntW'(1);
          res.err = 1'b1;
        end
        MODE_WORD: begin
          res.cnt   = CntW'(5);
          res.bytes = {wc_inc[31:24], wc_inc[23:16], wc_inc[15:8], wc_inc[7:0], CH_NUL};
          res.tgt   = {{4{TGT_HEADER}}, TGT_BODY};
        end
        default: begin
          res.cnt   = CntW'(4);
          res.bytes = {CH_NUL, wc_r[31:24], wc_r[23:16], wc_r[15:8], wc_r[7:0]};
          res.tgt   = {TGT_BODY, {4{TGT_HEADER}}};
        end
      endcase
      mode_nxt   = MODE_LINE;
      accum_nxt  = '0;
      over_nxt   = 1'b0;
      neg_nxt    = 1'b0;
      digits_nxt = 1'b0;
      wc_nxt     = '0;
    end else begin
      unique case (mode_r)
        MODE_LINE: begin
          if (is_space) begin
            mode_nxt = MODE_LINE;
          end else if ((text_byte == CH_PLUS) || (text_byte == CH_MINUS)) begin
            accum_nxt  = '0;
            over_nxt   = 1'b0;
            neg_nxt    = (text_byte == CH_MINUS);
            digits_nxt = 1'b0;
            mode_nxt   = MODE_NUMBER;
          end else if (is_digit) begin
            accum_nxt  = {12'd0, digit};
            over_nxt   = 1'b0;
            neg_nxt    = 1'b0;
            digits_nxt = 1'b1;
            mode_nxt   = MODE_NUMBER;
          end else begin
            mode_nxt = MODE_ERROR;
            res.cnt  = CntW'(1);
            res.err  = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit) begin
            accum_nxt  = prod[15:0];
            over_nxt   = over_r | (prod[19:16] != 4'd0);
            digits_nxt = 1'b1;
          end else if ((text_byte == CH_SPACE) && digits_r) begin
            res.cnt       = CntW'(2);
            res.bytes[0]  = weight[7:0];
            res.bytes[1]  = weight[15:8];
            accum_nxt     = '0;
            over_nxt      = 1'b0;
            neg_nxt       = 1'b0;
            digits_nxt    = 1'b0;
            mode_nxt      = MODE_WORD;
          end else begin
            mode_nxt = MODE_ERROR;
            res.cnt  = CntW'(1);
            res.err  = 1'b1;
          end
        end
        MODE_WORD: begin
          res.cnt = CntW'(1);
          if ((text_byte == CH_NL) || (text_byte == CH_NUL)) begin
            res.bytes[0] = CH_NUL;
            wc_nxt       = wc_inc;
            mode_nxt     = MODE_LINE;
          end else begin
            res.bytes[0] = text_byte;
          end
        end
        default: begin
          mode_nxt = MODE_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_LINE;
      accum_r  <= '0;
      over_r   <= 1'b0;
      neg_r    <= 1'b0;
      digits_r <= 1'b0;
      wc_r     <= '0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      accum_r  <= accum_nxt;
      over_r   <= over_nxt;
      neg_r    <= neg_nxt;
      digits_r <= digits_nxt;
      wc_r     <= wc_nxt;
    end
  end

endmodule

// ----- rtl/text_dict_to_binary_records_top.sv -----
// Top level of the text dictionary to binary record converter: parser and
// result register handing out one result per unstalled cycle. Depends on td2b_pkg, td2b_parse.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_kind, in_text_byte
//   out     | output    | out_valid/out_stall | out_byte, out_target, out_error, out_last
//
// An item is parsed in the cycle it is transferred; its results (0 to 5) are
// held and leave one per cycle, while out_stall is low, from the next cycle on.
// Items with at most one result go back to back; after a weight or end of input
// the next item waits until the last result leaves the single result port. Reset
// returns the parser to line start with a zero word count. out_stall holds the
// current result; while results are held, the input stalls but for the last one's transfer.
module text_dict_to_binary_records_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_target,
  output logic       out_error,
  output logic       out_last
);
  import td2b_pkg::*;

  bundle_t         res;
  bundle_t         bun_r;
  logic [CntW-1:0] rem_r, rem_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic            in_xfer, out_xfer;

  assign out_valid = (rem_r != '0);
  assign out_last  = (rem_r == CntW'(1));
  assign out_xfer  = out_valid && !out_stall;
  assign in_stall  = out_valid && !(out_last && !out_stall);
  assign in_xfer   = in_valid && !in_stall;

  assign out_byte   = bun_r.bytes[idx_r];
  assign out_target = bun_r.tgt[idx_r];
  assign out_error  = bun_r.err;

  td2b_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_xfer),
    .kind      (in_kind),
    .text_byte (in_text_byte),
    .res       (res)
  );

  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (in_xfer) begin
      rem_nxt = res.cnt;
      idx_nxt = '0;
    end else if (out_xfer) begin
      rem_nxt = rem_r - CntW'(1);
      idx_nxt = idx_r + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      idx_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      bun_r <= res;
    end
  end

  a_held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, idx_r} + {1'b0, rem_r}) <= (CntW+1)'(NumRes))
    else $error("held result index beyond bundle");

  a_load_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && out_valid) |-> (out_last && !out_stall))
    else $error("new item taken while results still held");

  a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_last && (idx_r == '0) && (out_byte == CH_NUL)))
    else $error("error result not a lone zero result");

  a_header_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_target && !out_last) |=> (out_valid && out_target))
    else $error("header bytes interrupted");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for text_dict_to_binary_records_top: feeds text dictionaries one byte per transfer,
// idles both channels at random and checks each output byte against a local predictor.
// Depends on td2b_pkg and the converter RTL.
module testbench;
  import td2b_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomItems   = 75;

  typedef struct packed {
    logic [7:0] value;
    logic       target;
    logic       error;
    logic       last;
  } out_rec_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_kind;
  logic [7:0] in_text_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_target;
  logic       out_error;
  logic       out_last;

  // predictor state
  logic [1:0]  p_mode;
  logic [15:0] p_accum;
  logic        p_over;
  logic        p_neg;
  logic        p_digits;
  logic [31:0] p_words;

  out_rec_t expected_bytes[$];
  out_rec_t exp_rec;
  int       err_count;
  int       items_sent;
  int       results_seen;
  int       dicts_closed;
  int       idle_cycles;
  int       stall_left;
  bit       quiet;

  text_dict_to_binary_records_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_text_byte (in_text_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_target   (out_target),
    .out_error    (out_error),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 15) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic clear_weight();
    p_accum  = '0;
    p_over   = 1'b0;
    p_neg    = 1'b0;
    p_digits = 1'b0;
  endtask

  task automatic reset_parser();
    p_mode  = MODE_LINE;
    p_words = '0;
    clear_weight();
  endtask

  // Expected output bytes for one accepted item.
  task automatic convert_item(input logic k, input logic [7:0] c);
    out_rec_t    recs[$];
    logic [31:0] v;
    logic [15:0] w;
    if (k == KIND_EOI) begin
      if (p_mode == MODE_NUMBER || p_mode == MODE_ERROR) begin
        recs.push_back('{8'h00, TGT_BODY, 1'b1, 1'b0});
      end else begin
        if (p_mode == MODE_WORD) begin
          recs.push_back('{8'h00, TGT_BODY, 1'b0, 1'b0});
          p_words = p_words + 1;
        end
        for (int i = 0; i < 4; i++) recs.push_back('{p_words[8*i +: 8], TGT_HEADER, 1'b0, 1'b0});
      end
      reset_parser();
      dicts_closed++;
    end else begin
      case (p_mode)
        MODE_LINE: begin
          if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            clear_weight();
            p_neg  = (c == CH_MINUS);
            p_mode = MODE_NUMBER;
          end else if (is_digit(c)) begin
            clear_weight();
            p_accum  = 16'(c - CH_ZERO);
            p_digits = 1'b1;
            p_mode   = MODE_NUMBER;
          end else begin
            p_mode = MODE_ERROR;
            recs.push_back('{8'h00, TGT_BODY, 1'b1, 1'b0});
          end
        end
        MODE_NUMBER: begin
          if (is_digit(c)) begin
            v = 32'(p_accum) * 10 + 32'(c - CH_ZERO);
            if (v > 32'h0000_FFFF) p_over = 1'b1;
            p_accum  = v[15:0];
            p_digits = 1'b1;
          end else if (c == CH_SPACE && p_digits) begin
            if (p_neg) w = 16'h0000 - p_accum;
            else w = p_over ? 16'hFFFF : p_accum;
            recs.push_back('{w[7:0], TGT_BODY, 1'b0, 1'b0});
            recs.push_back('{w[15:8], TGT_BODY, 1'b0, 1'b0});
            clear_weight();
            p_mode = MODE_WORD;
          end else begin
            p_mode = MODE_ERROR;
            recs.push_back('{8'h00, TGT_BODY, 1'b1, 1'b0});
          end
        end
        MODE_WORD: begin
          if (c == CH_NL || c == CH_NUL) begin
            recs.push_back('{8'h00, TGT_BODY, 1'b0, 1'b0});
            p_words = p_words + 1;
            p_mode  = MODE_LINE;
          end else begin
            recs.push_back('{c, TGT_BODY, 1'b0, 1'b0});
          end
        end
        default: begin
        end
      endcase
    end
    if (recs.size() > 0) recs[recs.size() - 1].last = 1'b1;
    foreach (recs[i]) expected_bytes.push_back(recs[i]);
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  task automatic send_item(input logic k, input logic [7:0] c);
    int gap;
    gap = quiet ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid     = 1'b1;
    in_kind      = k;
    in_text_byte = c;
    do @(posedge clk); while (in_stall);
    convert_item(k, c);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(KIND_TEXT, s[i]);
  endtask

  task automatic send_eoi();
    send_item(KIND_EOI, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_bytes.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  // transfer check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte %h", out_byte));
      end else begin
        exp_rec = expected_bytes.pop_front();
        if (out_byte !== exp_rec.value)
          report_mismatch($sformatf("byte %h, expected %h", out_byte, exp_rec.value));
        if (out_target !== exp_rec.target)
          report_mismatch($sformatf("target %b, expected %b", out_target, exp_rec.target));
        if (out_error !== exp_rec.error)
          report_mismatch($sformatf("error %b, expected %b", out_error, exp_rec.error));
        if (out_last !== exp_rec.last)
          report_mismatch($sformatf("last %b, expected %b", out_last, exp_rec.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("text_dict_to_binary_records_top test failed");
        $finish;
      end
    end
  end

  initial begin
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall  = 1'b1;
        stall_left = pick_gap();
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  task automatic test_plain_line();
    quiet = 1'b1;
    send_text("\t 7 a\n");
    send_eoi();
    quiet = 1'b0;
  endtask

  task automatic test_weight_extremes();
    send_text("+99999 ");
    send_item(KIND_TEXT, 8'hFF);
    send_item(KIND_TEXT, CH_NUL);
    send_text("-1 ");
    send_eoi();
    wait_for_drain();
  endtask

  task automatic test_malformed_lines();
    send_text("x5");
    send_eoi();
    send_text("+-1");
    send_eoi();
    send_text("- ");
    send_eoi();
    send_text("3a");
    send_eoi();
    send_text("5");
    send_eoi();
  endtask

  task automatic send_random_line();
    int         n;
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) begin
      send_item(KIND_TEXT, 8'($urandom_range(0, 255)));
      return;
    end
    n = $urandom_range(0, 2);
    repeat (n) begin
      c = ($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
      send_item(KIND_TEXT, c);
    end
    case ($urandom_range(0, 5))
      0: send_item(KIND_TEXT, CH_MINUS);
      1: send_item(KIND_TEXT, CH_PLUS);
      default: begin
      end
    endcase
    n = ($urandom_range(0, 15) == 0) ? 0 : ($urandom_range(0, 3) == 0 ? 5 : $urandom_range(1, 3));
    repeat (n) send_item(KIND_TEXT, 8'(CH_ZERO + $urandom_range(0, 9)));
    send_item(KIND_TEXT, CH_SPACE);
    n = $urandom_range(0, 5);
    repeat (n) send_item(KIND_TEXT, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) != 0)
      send_item(KIND_TEXT, ($urandom_range(0, 3) == 0) ? CH_NUL : CH_NL);
  endtask

  task automatic test_random_dictionaries();
    int stop_at;
    int lines;
    stop_at = items_sent + RandomItems;
    while (items_sent < stop_at) begin
      quiet = ($urandom_range(0, 3) == 0);
      lines = $urandom_range(1, 4);
      repeat (lines) send_random_line();
      send_eoi();
      if ($urandom_range(0, 3) == 0) wait_for_drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = KIND_TEXT;
    in_text_byte = 8'h00;
    out_stall    = 1'b0;
    quiet        = 1'b0;
    err_count    = 0;
    items_sent   = 0;
    results_seen = 0;
    dicts_closed = 0;
    idle_cycles  = 0;
    reset_parser();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_plain_line();
    test_weight_extremes();
    test_malformed_lines();
    test_random_dictionaries();

    quiet = 1'b1;
    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_bytes.size() == 0);
    repeat (10) @(posedge clk);

    $display("covered %0d input transfers, %0d output bytes, %0d dictionaries closed",
             items_sent, results_seen, dicts_closed);
    if (err_count == 0 && expected_bytes.size() == 0) begin
      $display("text_dict_to_binary_records_top test passed");
    end else begin
      $display("text_dict_to_binary_records_top test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/td2b_pkg.sv
rtl/td2b_parse.sv
rtl/text_dict_to_binary_records_top.sv
sim/testbench.sv
